FILE: hdl/sbt_pkg.sv
// Shared types, widths and constants of the send bandwidth throttle.
package sbt_pkg;

    // Field widths.
    localparam int SENT_W    = 31;
    localparam int LEN_W     = 31;
    localparam int ELAP_W    = 40;
    localparam int CFG_W     = 31;
    localparam int CREDIT_W  = 32;
    localparam int CFG_IDX_W = 2;

    // Datapath widths.
    localparam int OPND_W    = 32;
    localparam int PROD_W    = 2 * OPND_W;
    localparam int SCALED_W  = 44;                 // sent_bytes * 8000
    localparam int QUO_W     = 45;                 // quotient bits produced per division
    localparam int IDLE_W    = SENT_W + ELAP_W;    // elapsed * sent_bytes
    localparam int SUB_W     = QUO_W + 1;
    localparam int SUM_W     = 48;
    localparam int CNT_W     = $clog2(QUO_W + 1);
    localparam int X25_W     = CFG_W + 5;

    // Constants of the pacing rule.
    localparam logic [CFG_W-1:0]  THRESHOLD_RESET  = 31'd100000;
    localparam logic [CFG_W-1:0]  MAX_CREDIT_RESET = 31'd5000000;
    localparam logic [OPND_W-1:0] BITS_PER_KBYTE   = 32'd8000;
    localparam logic [CFG_W-1:0]  BW_LIMIT_MAX     = 31'd85899345;
    localparam logic [SUB_W-1:0]  IDLE_SAT         = SUB_W'(1) << QUO_W;
    localparam logic [SUM_W-1:0]  CREDIT_MAX       = SUM_W'(32'h7FFF_FFFF);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BANDWIDTH  = 2'd0,
        CFG_THRESHOLD  = 2'd1,
        CFG_MAX_CREDIT = 2'd2
    } cfg_idx_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_ADD,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_PROD,
        ST_WAIT_ADD,
        ST_WAIT_SUB,
        ST_SUM,
        ST_FINISH
    } state_t;

    // Request to the shared divider.
    typedef struct packed {
        logic              start;
        logic [LEN_W-1:0]  rem_init;
        logic [QUO_W-1:0]  dividend;
        logic [LEN_W-1:0]  divisor;
    } div_req_t;

endpackage

FILE: hdl/sbt_if.sv
// Valid/ready channel interfaces for send chunks and throttle results.
interface sbt_chunk_if;
    import sbt_pkg::*;

    logic              valid;
    logic              ready;
    logic [SENT_W-1:0] sent_bytes;
    logic [LEN_W-1:0]  message_len;
    logic [ELAP_W-1:0] elapsed_us;
    logic              tracked;

    modport source (output valid, sent_bytes, message_len, elapsed_us, tracked, input ready);
    modport sink   (input valid, sent_bytes, message_len, elapsed_us, tracked, output ready);
endinterface

interface sbt_result_if;
    import sbt_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [CFG_W-1:0]           sleep_us;
    logic [LEN_W-1:0]           chunk_limit;
    logic signed [CREDIT_W-1:0] credit_us;

    modport source (output valid, sleep_us, chunk_limit, credit_us, input ready);
    modport sink   (input valid, sleep_us, chunk_limit, credit_us, output ready);
endinterface

FILE: hdl/sbt_mul.sv
// Shared 32 x 32 multiplier with a registered product.
module sbt_mul (
    input  logic                         clk,
    input  logic [sbt_pkg::OPND_W-1:0]   a,
    input  logic [sbt_pkg::OPND_W-1:0]   b,
    output logic [sbt_pkg::PROD_W-1:0]   prod
);
    import sbt_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;

    assign prod_next = PROD_W'(a) * PROD_W'(b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

FILE: hdl/sbt_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module sbt_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sbt_pkg::div_req_t           req,
    output logic                        done,
    output logic [sbt_pkg::QUO_W-1:0]   quotient
);
    import sbt_pkg::*;

    logic [LEN_W-1:0] rem_reg;
    logic [LEN_W-1:0] rem_next;
    logic [QUO_W-1:0] quo_reg;
    logic [QUO_W-1:0] quo_next;
    logic [LEN_W-1:0] divisor_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;

    logic [LEN_W:0]   shifted;
    logic [LEN_W+1:0] diff;
    logic             fits;

    // The remainder always stays below the divisor, so it fits in LEN_W bits.
    assign shifted = {rem_reg, quo_reg[QUO_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, divisor_reg};
    assign fits    = !diff[LEN_W+1];

    always_comb
    begin
        rem_next = fits ? diff[LEN_W-1:0] : shifted[LEN_W-1:0];
        quo_next = {quo_reg[QUO_W-2:0], fits};
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            cnt_next  = CNT_W'(QUO_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg     <= req.rem_init;
            quo_reg     <= req.dividend;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: hdl/send_bandwidth_throttle.sv
// Top level of the send bandwidth throttle: sequencer, credit state and configuration.
//
//   channel  direction  handshake      carries
//   chunk    in         valid/ready    sent_bytes, message_len, elapsed_us, tracked
//   result   out        valid/ready    sleep_us, chunk_limit, credit_us
//   cfg      in         cfg_we only    cfg_index, cfg_wdata
//
// A tracked chunk with a nonzero bandwidth reaches its result through the multiplier states and
// two 45-step passes through the shared radix-2 divider; a zero message length or a saturated
// idle term skips the second pass. Other chunks go from idle straight to the finish state. Reset
// clears the credit to zero and loads the register defaults. A new chunk is taken only while the
// sequencer is idle; a waiting result stays in the output register and holds the sequencer's
// next result back.
module send_bandwidth_throttle (
    input  logic                          clk,
    input  logic                          rst_n,
    sbt_chunk_if.sink                     chunk,
    sbt_result_if.source                  result,
    input  logic                          cfg_we,
    input  logic [sbt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sbt_pkg::CFG_W-1:0]     cfg_wdata
);
    import sbt_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Configuration.
    logic [CFG_W-1:0] bw_reg;
    logic [CFG_W-1:0] thr_reg;
    logic [CFG_W-1:0] maxc_reg;

    // Captured transaction.
    logic [SENT_W-1:0] sent_reg;
    logic [LEN_W-1:0]  mlen_reg;
    logic [ELAP_W-1:0] elap_reg;
    logic              upd_reg;

    // Datapath.
    logic [OPND_W-1:0]   mul_a;
    logic [OPND_W-1:0]   mul_b;
    logic [PROD_W-1:0]   prod;
    logic [PROD_W-1:0]   plo_reg;
    logic [IDLE_W-1:0]   pbig_reg;
    logic [SCALED_W-1:0] add_reg;
    logic [SUB_W-1:0]    sub_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic signed [CREDIT_W-1:0] credit_reg;

    div_req_t         div_req;
    logic             div_done;
    logic [QUO_W-1:0] div_quo;

    // Output register.
    logic             res_valid_reg;
    logic [CFG_W-1:0] sleep_reg;
    logic [LEN_W-1:0] limit_reg;

    // Sequencer outputs.
    logic take_in;
    logic cap_plo;
    logic cap_pbig;
    logic cap_add;
    logic cap_sub_direct;
    logic cap_sub_div;
    logic cap_sum;
    logic finish;

    logic out_free;
    logic idle_zero;
    logic idle_sat;
    logic start_update;

    logic [SUM_W-1:0]    neg_max;
    logic [CREDIT_W-1:0] clamped;
    logic                sleep_hit;
    logic [CREDIT_W-1:0] credit_new;
    logic [CFG_W-1:0]    sleep_new;
    logic [X25_W-1:0]    bw_x25;
    logic [LEN_W-1:0]    limit_new;

    sbt_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    sbt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign out_free     = !res_valid_reg || result.ready;
    assign start_update = chunk.tracked && (bw_reg != '0);
    assign idle_zero    = (mlen_reg == '0);
    // When the top bits of the product already reach the divisor, the idle term is at least
    // 2^45 and the credit saturates low whatever the exact value.
    assign idle_sat     = (LEN_W'(pbig_reg[IDLE_W-1:QUO_W]) >= mlen_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (chunk.valid)
                begin
                    state_next = start_update ? ST_MUL_ADD : ST_FINISH;
                end
            end
            ST_MUL_ADD:  state_next = ST_MUL_LO;
            ST_MUL_LO:   state_next = ST_MUL_HI;
            ST_MUL_HI:   state_next = ST_PROD;
            ST_PROD:     state_next = ST_WAIT_ADD;
            ST_WAIT_ADD:
            begin
                if (div_done)
                begin
                    state_next = (idle_zero || idle_sat) ? ST_SUM : ST_WAIT_SUB;
                end
            end
            ST_WAIT_SUB:
            begin
                if (div_done)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:      state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        take_in        = 1'b0;
        cap_plo        = 1'b0;
        cap_pbig       = 1'b0;
        cap_add        = 1'b0;
        cap_sub_direct = 1'b0;
        cap_sub_div    = 1'b0;
        cap_sum        = 1'b0;
        finish         = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        div_req        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                take_in = chunk.valid;
            end
            ST_MUL_ADD:
            begin
                mul_a = OPND_W'(sent_reg);
                mul_b = BITS_PER_KBYTE;
            end
            ST_MUL_LO:
            begin
                mul_a            = elap_reg[OPND_W-1:0];
                mul_b            = OPND_W'(sent_reg);
                div_req.start    = 1'b1;
                div_req.rem_init = '0;
                div_req.dividend = QUO_W'(prod[SCALED_W-1:0]);
                div_req.divisor  = bw_reg;
            end
            ST_MUL_HI:
            begin
                mul_a   = OPND_W'(elap_reg[ELAP_W-1:OPND_W]);
                mul_b   = OPND_W'(sent_reg);
                cap_plo = 1'b1;
            end
            ST_PROD:
            begin
                cap_pbig = 1'b1;
            end
            ST_WAIT_ADD:
            begin
                cap_add        = div_done;
                cap_sub_direct = div_done && (idle_zero || idle_sat);
                if (div_done && !idle_zero && !idle_sat)
                begin
                    div_req.start    = 1'b1;
                    div_req.rem_init = LEN_W'(pbig_reg[IDLE_W-1:QUO_W]);
                    div_req.dividend = pbig_reg[QUO_W-1:0];
                    div_req.divisor  = mlen_reg;
                end
            end
            ST_WAIT_SUB:
            begin
                cap_sub_div = div_done;
            end
            ST_SUM:
            begin
                cap_sum = 1'b1;
            end
            ST_FINISH:
            begin
                finish = out_free;
            end
            default:
            begin
                take_in = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bw_reg   <= '0;
            thr_reg  <= THRESHOLD_RESET;
            maxc_reg <= MAX_CREDIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BANDWIDTH:  bw_reg   <= cfg_wdata;
                CFG_THRESHOLD:  thr_reg  <= cfg_wdata;
                CFG_MAX_CREDIT: maxc_reg <= cfg_wdata;
                default:        bw_reg   <= bw_reg;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            sent_reg <= chunk.sent_bytes;
            mlen_reg <= chunk.message_len;
            elap_reg <= chunk.elapsed_us;
            upd_reg  <= start_update;
        end
        if (cap_plo)
        begin
            plo_reg <= prod;
        end
        if (cap_pbig)
        begin
            pbig_reg <= (IDLE_W'(prod) << OPND_W) + IDLE_W'(plo_reg);
        end
        if (cap_add)
        begin
            add_reg <= div_quo[SCALED_W-1:0];
        end
        if (cap_sub_direct)
        begin
            sub_reg <= idle_zero ? '0 : IDLE_SAT;
        end
        else if (cap_sub_div)
        begin
            sub_reg <= SUB_W'(div_quo);
        end
        if (cap_sum)
        begin
            sum_reg <= SUM_W'(credit_reg) + SUM_W'(add_reg) - SUM_W'(sub_reg);
        end
        if (finish)
        begin
            sleep_reg <= sleep_new;
            limit_reg <= limit_new;
        end
    end

    // Clamp to the credit floor and the 32-bit ceiling, then test for a sleep.
    always_comb
    begin
        neg_max = '0 - SUM_W'(maxc_reg);
        if ($signed(sum_reg) < $signed(neg_max))
        begin
            clamped = neg_max[CREDIT_W-1:0];
        end
        else if ($signed(sum_reg) > $signed(CREDIT_MAX))
        begin
            clamped = CREDIT_MAX[CREDIT_W-1:0];
        end
        else
        begin
            clamped = sum_reg[CREDIT_W-1:0];
        end
        sleep_hit = $signed(clamped) > $signed({1'b0, thr_reg});
        if (upd_reg && sleep_hit)
        begin
            credit_new = '0;
            sleep_new  = clamped[CFG_W-1:0];
        end
        else if (upd_reg)
        begin
            credit_new = clamped;
            sleep_new  = '0;
        end
        else
        begin
            credit_new = credit_reg;
            sleep_new  = '0;
        end
    end

    // Chunk size limit: bandwidth * 25 / 2, or the message length when unlimited or above BW_LIMIT_MAX.
    always_comb
    begin
        bw_x25 = (X25_W'(bw_reg) << 4) + (X25_W'(bw_reg) << 3) + X25_W'(bw_reg);
        if ((bw_reg == '0) || (bw_reg > BW_LIMIT_MAX))
        begin
            limit_new = mlen_reg;
        end
        else
        begin
            limit_new = bw_x25[LEN_W:1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (finish)
            begin
                credit_reg    <= credit_new;
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign chunk.ready        = (state_reg == ST_IDLE);
    assign result.valid       = res_valid_reg;
    assign result.sleep_us    = sleep_reg;
    assign result.chunk_limit = limit_reg;
    assign result.credit_us   = credit_reg;

endmodule
